[rtl/sip_pkg.sv]
// Shared widths and the side-band record for the segment intersection point unit.
// Depends on nothing; imported by the divider pipeline and the top level.
package sip_pkg;

  localparam int COORD_BITS = 21;
  localparam int FRAC_BITS  = 32;
  localparam int PT_W       = 53;

  localparam int DIFF_W  = COORD_BITS + 1;       // coordinate difference
  localparam int MUL_W   = 2 * DIFF_W;           // product of two differences
  localparam int CROSS_W = MUL_W + 1;            // cross product, determinant
  localparam int EM_W    = 2 * COORD_BITS;       // product of two coordinates
  localparam int E_W     = EM_W + 1;             // line constant x0*y1 - y0*x1
  localparam int PROD_W  = E_W + DIFF_W;         // line constant times difference
  localparam int NUM_W   = PROD_W + 1;           // determinant numerator
  localparam int DVD_W   = NUM_W + FRAC_BITS;    // scaled numerator magnitude
  localparam int DEN_W   = CROSS_W;              // divisor magnitude
  localparam int DIV_SPS = 2;                    // quotient bits per divider stage
  localparam int DIV_STG = (DVD_W + DIV_SPS - 1) / DIV_SPS;

  // Result flags and the collinear touch point travel beside the quotients.
  typedef struct packed {
    logic            meets;
    logic            pvld;
    logic            use_div;
    logic            negx;
    logic            negy;
    logic [PT_W-1:0] cp_x;
    logic [PT_W-1:0] cp_y;
  } side_t;

endpackage

[rtl/segment_intersection_point_unit.sv]
// Top level of the segment intersection point unit: front-end arithmetic pipeline,
// divider pipeline (sip_div) and output register. Depends on sip_pkg.
//
// Each request carries two segments with integer endpoints. The unit answers
// whether the segments share a point and, when a single point can be named, gives
// it in signed fixed point with FRAC_BITS fraction bits, truncated toward zero.
// Crossing lines give the determinant quotient; collinear segments give a point
// only when they touch end to end. The unit is a fixed pipeline: a request can be
// accepted in every cycle unless the output stalls as told below. DIV_STG is the
// number of divider stages, each stage producing two quotient bits of the scaled
// numerator. Five front stages form the differences and sorted endpoints, the
// pairwise products, the cross products and line constants, the orientation
// decision with the wide numerator products, and the numerator magnitudes. The
// whole pipeline holds while a finished result waits at the output register and
// the downstream side is not ready; nothing is dropped or repeated.
module segment_intersection_point_unit import sip_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] s1_x0_i,
  input  logic signed [COORD_BITS-1:0] s1_y0_i,
  input  logic signed [COORD_BITS-1:0] s1_x1_i,
  input  logic signed [COORD_BITS-1:0] s1_y1_i,
  input  logic signed [COORD_BITS-1:0] s2_x0_i,
  input  logic signed [COORD_BITS-1:0] s2_y0_i,
  input  logic signed [COORD_BITS-1:0] s2_x1_i,
  input  logic signed [COORD_BITS-1:0] s2_y1_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         meets_o,
  output logic                         point_valid_o,
  output logic signed [PT_W-1:0]       point_x_o,
  output logic signed [PT_W-1:0]       point_y_o
);

  localparam int QX_W = (DVD_W > PT_W) ? DVD_W : PT_W;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  function automatic logic signed [DIFF_W-1:0] dif(logic signed [COORD_BITS-1:0] p,
                                                   logic signed [COORD_BITS-1:0] q);
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

  function automatic logic signed [MUL_W-1:0] mul(logic signed [DIFF_W-1:0] p,
                                                  logic signed [DIFF_W-1:0] q);
    return MUL_W'(p) * MUL_W'(q);
  endfunction

  function automatic logic signed [EM_W-1:0] cmul(logic signed [COORD_BITS-1:0] p,
                                                  logic signed [COORD_BITS-1:0] q);
    return EM_W'(p) * EM_W'(q);
  endfunction

  function automatic logic signed [CROSS_W-1:0] csub(logic signed [MUL_W-1:0] p,
                                                     logic signed [MUL_W-1:0] q);
    return CROSS_W'(p) - CROSS_W'(q);
  endfunction

  function automatic logic signed [PROD_W-1:0] wmul(logic signed [E_W-1:0] e,
                                                    logic signed [DIFF_W-1:0] q);
    return PROD_W'(e) * PROD_W'(q);
  endfunction

  // Lexicographic order on (x, y).
  function automatic logic pt_le(pt_t p, pt_t q);
    return (p.x < q.x) || ((p.x == q.x) && (p.y <= q.y));
  endfunction

  function automatic logic [PT_W-1:0] fixint(logic signed [COORD_BITS-1:0] v);
    logic signed [PT_W-1:0] w;
    w = PT_W'(v);
    return w << FRAC_BITS;
  endfunction

  logic en;
  logic out_vld_q;

  // Hold every stage while the output register is full and not taken.
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------------------------------------------------------- stage 1
  pt_t pa, pb, pc, pd;
  assign pa = '{x: s1_x0_i, y: s1_y0_i};
  assign pb = '{x: s1_x1_i, y: s1_y1_i};
  assign pc = '{x: s2_x0_i, y: s2_y0_i};
  assign pd = '{x: s2_x1_i, y: s2_y1_i};

  logic                     v1_q;
  logic signed [DIFF_W-1:0] bax_q, bay_q, cax_q, cay_q, dax_q, day_q;
  logic signed [DIFF_W-1:0] dcx_q, dcy_q, acx_q, acy_q, bcx_q, bcy_q;
  pt_t                      a1_q, b1_q, c1_q, d1_q;
  pt_t                      sa_q, sb_q, sc_q, sd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bax_q <= dif(pb.x, pa.x);
      bay_q <= dif(pb.y, pa.y);
      cax_q <= dif(pc.x, pa.x);
      cay_q <= dif(pc.y, pa.y);
      dax_q <= dif(pd.x, pa.x);
      day_q <= dif(pd.y, pa.y);
      dcx_q <= dif(pd.x, pc.x);
      dcy_q <= dif(pd.y, pc.y);
      acx_q <= dif(pa.x, pc.x);
      acy_q <= dif(pa.y, pc.y);
      bcx_q <= dif(pb.x, pc.x);
      bcy_q <= dif(pb.y, pc.y);
      a1_q  <= pa;
      b1_q  <= pb;
      c1_q  <= pc;
      d1_q  <= pd;
      // Sort each segment's endpoints for the collinear span test.
      sa_q  <= pt_le(pa, pb) ? pa : pb;
      sb_q  <= pt_le(pa, pb) ? pb : pa;
      sc_q  <= pt_le(pc, pd) ? pc : pd;
      sd_q  <= pt_le(pc, pd) ? pd : pc;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                     v2_q;
  logic signed [MUL_W-1:0]  m_abc1_q, m_abc2_q, m_abd1_q, m_abd2_q;
  logic signed [MUL_W-1:0]  m_cda1_q, m_cda2_q, m_cdb1_q, m_cdb2_q;
  logic signed [MUL_W-1:0]  m_den1_q, m_den2_q;
  logic signed [EM_W-1:0]   m_e11_q, m_e12_q, m_e21_q, m_e22_q;
  logic signed [DIFF_W-1:0] bax2_q, bay2_q, dcx2_q, dcy2_q;
  logic                     cmeet2_q, chit2_q;
  logic [PT_W-1:0]          cpx2_q, cpy2_q;

  logic hit_hi, hit_lo;
  // Upper end of segment one on the lower end of segment two, else the reverse.
  assign hit_hi = (sb_q == sc_q) && pt_le(sa_q, sc_q);
  assign hit_lo = (sa_q == sd_q) && pt_le(sc_q, sa_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_abc1_q <= mul(bax_q, cay_q);
      m_abc2_q <= mul(bay_q, cax_q);
      m_abd1_q <= mul(bax_q, day_q);
      m_abd2_q <= mul(bay_q, dax_q);
      m_cda1_q <= mul(dcx_q, acy_q);
      m_cda2_q <= mul(dcy_q, acx_q);
      m_cdb1_q <= mul(dcx_q, bcy_q);
      m_cdb2_q <= mul(dcy_q, bcx_q);
      m_den1_q <= mul(bax_q, dcy_q);
      m_den2_q <= mul(bay_q, dcx_q);
      m_e11_q  <= cmul(a1_q.x, b1_q.y);
      m_e12_q  <= cmul(a1_q.y, b1_q.x);
      m_e21_q  <= cmul(c1_q.x, d1_q.y);
      m_e22_q  <= cmul(c1_q.y, d1_q.x);
      bax2_q   <= bax_q;
      bay2_q   <= bay_q;
      dcx2_q   <= dcx_q;
      dcy2_q   <= dcy_q;
      cmeet2_q <= pt_le(sa_q, sd_q) && pt_le(sc_q, sb_q);
      chit2_q  <= hit_hi || hit_lo;
      cpx2_q   <= hit_hi ? fixint(sb_q.x) : fixint(sa_q.x);
      cpy2_q   <= hit_hi ? fixint(sb_q.y) : fixint(sa_q.y);
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                      v3_q;
  logic signed [CROSS_W-1:0] o_abc_q, o_abd_q, o_cda_q, o_cdb_q, den3_q;
  logic signed [E_W-1:0]     e1_q, e2_q;
  logic signed [DIFF_W-1:0]  bax3_q, bay3_q, dcx3_q, dcy3_q;
  logic                      cmeet3_q, chit3_q;
  logic [PT_W-1:0]           cpx3_q, cpy3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_abc_q  <= csub(m_abc1_q, m_abc2_q);
      o_abd_q  <= csub(m_abd1_q, m_abd2_q);
      o_cda_q  <= csub(m_cda1_q, m_cda2_q);
      o_cdb_q  <= csub(m_cdb1_q, m_cdb2_q);
      den3_q   <= csub(m_den1_q, m_den2_q);
      e1_q     <= E_W'(m_e11_q) - E_W'(m_e12_q);
      e2_q     <= E_W'(m_e21_q) - E_W'(m_e22_q);
      bax3_q   <= bax2_q;
      bay3_q   <= bay2_q;
      dcx3_q   <= dcx2_q;
      dcy3_q   <= dcy2_q;
      cmeet3_q <= cmeet2_q;
      chit3_q  <= chit2_q;
      cpx3_q   <= cpx2_q;
      cpy3_q   <= cpy2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic ab_zero, ab_nonpos, cd_zero, cd_nonpos, meets4;
  assign ab_zero   = (o_abc_q == '0) || (o_abd_q == '0);
  assign ab_nonpos = ab_zero || (o_abc_q[CROSS_W-1] != o_abd_q[CROSS_W-1]);
  assign cd_zero   = (o_cda_q == '0) || (o_cdb_q == '0);
  assign cd_nonpos = cd_zero || (o_cda_q[CROSS_W-1] != o_cdb_q[CROSS_W-1]);
  assign meets4    = (ab_zero && cd_zero) ? cmeet3_q : (ab_nonpos && cd_nonpos);

  logic                      v4_q;
  logic signed [PROD_W-1:0]  wx1_q, wx2_q, wy1_q, wy2_q;
  logic signed [CROSS_W-1:0] den4_q;
  logic                      meets4_q, pvld4_q, usediv4_q;
  logic [PT_W-1:0]           cpx4_q, cpy4_q;

  // Numerators use the differences b - a and d - c with the line constants swapped,
  // so they match the textbook form; the determinant keeps its sign.
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx1_q     <= wmul(e2_q, bax3_q);
      wx2_q     <= wmul(e1_q, dcx3_q);
      wy1_q     <= wmul(e2_q, bay3_q);
      wy2_q     <= wmul(e1_q, dcy3_q);
      den4_q    <= den3_q;
      meets4_q  <= meets4;
      pvld4_q   <= meets4 && ((den3_q != '0) || chit3_q);
      usediv4_q <= den3_q != '0;
      cpx4_q    <= cpx3_q;
      cpy4_q    <= cpy3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic signed [NUM_W-1:0] numx, numy;
  assign numx = NUM_W'(wx1_q) - NUM_W'(wx2_q);
  assign numy = NUM_W'(wy1_q) - NUM_W'(wy2_q);

  logic             v5_q;
  side_t            side5_q;
  logic [DEN_W-1:0] dsr5_q;
  logic [NUM_W-1:0] magx5_q, magy5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q.meets   <= meets4_q;
      side5_q.pvld    <= pvld4_q;
      side5_q.use_div <= usediv4_q;
      side5_q.negx    <= numx[NUM_W-1] ^ den4_q[CROSS_W-1];
      side5_q.negy    <= numy[NUM_W-1] ^ den4_q[CROSS_W-1];
      side5_q.cp_x    <= cpx4_q;
      side5_q.cp_y    <= cpy4_q;
      dsr5_q          <= den4_q[CROSS_W-1] ? DEN_W'(-den4_q) : DEN_W'(den4_q);
      magx5_q         <= numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
      magy5_q         <= numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);
    end
  end

  // Advance the valid bits with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------- divider
  logic             div_vld;
  side_t            div_side;
  logic [DVD_W-1:0] qx, qy;

  sip_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v5_q),
    .side_i (side5_q),
    .dsr_i  (dsr5_q),
    .dvdx_i ({magx5_q, FRAC_BITS'(0)}),
    .dvdy_i ({magy5_q, FRAC_BITS'(0)}),
    .vld_o  (div_vld),
    .side_o (div_side),
    .qx_o   (qx),
    .qy_o   (qy)
  );

  // ---------------------------------------------------------------- output
  logic [QX_W-1:0] qx_ext, qy_ext;
  logic [PT_W-1:0] qxl, qyl, px_d, py_d;

  always_comb begin
    qx_ext = QX_W'(qx);
    qy_ext = QX_W'(qy);
    qxl    = div_side.negx ? PT_W'(-qx_ext[PT_W-1:0]) : qx_ext[PT_W-1:0];
    qyl    = div_side.negy ? PT_W'(-qy_ext[PT_W-1:0]) : qy_ext[PT_W-1:0];
    if (!div_side.pvld) begin
      px_d = '0;
      py_d = '0;
    end else if (div_side.use_div) begin
      px_d = qxl;
      py_d = qyl;
    end else begin
      px_d = div_side.cp_x;
      py_d = div_side.cp_y;
    end
  end

  logic            meets_q, pvld_q;
  logic [PT_W-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meets_q <= div_side.meets;
      pvld_q  <= div_side.pvld;
      px_q    <= px_d;
      py_q    <= py_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign meets_o       = meets_q;
  assign point_valid_o = pvld_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;

endmodule

[rtl/sip_div.sv]
// Pipelined restoring divider for the x and y numerators over one shared divisor.
// Depends on sip_pkg for widths and the side-band record.
module sip_div import sip_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  side_t            side_i,
  input  logic [DEN_W-1:0] dsr_i,
  input  logic [DVD_W-1:0] dvdx_i,
  input  logic [DVD_W-1:0] dvdy_i,
  output logic             vld_o,
  output side_t            side_o,
  output logic [DVD_W-1:0] qx_o,
  output logic [DVD_W-1:0] qy_o
);

  // Remainder on top, remaining dividend bits shifting out while quotient bits shift in.
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
  } dpart_t;

  typedef struct packed {
    side_t            side;
    logic [DEN_W-1:0] dsr;
    dpart_t           x;
    dpart_t           y;
  } dstg_t;

  function automatic dpart_t div_step(dpart_t p, logic [DEN_W-1:0] d);
    logic [DEN_W:0] r2;
    dpart_t         n;
    r2    = {p.rem, p.dvd[DVD_W-1]};
    n.dvd = {p.dvd[DVD_W-2:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      n.rem    = DEN_W'(r2 - {1'b0, d});
      n.dvd[0] = 1'b1;
    end else begin
      n.rem = r2[DEN_W-1:0];
    end
    return n;
  endfunction

  dstg_t stg_in [DIV_STG+1];
  dstg_t stg_q  [DIV_STG];
  logic  vld_q  [DIV_STG];

  always_comb begin
    stg_in[0].side  = side_i;
    stg_in[0].dsr   = dsr_i;
    stg_in[0].x.rem = '0;
    stg_in[0].x.dvd = dvdx_i;
    stg_in[0].y.rem = '0;
    stg_in[0].y.dvd = dvdy_i;
  end

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    dstg_t stg_d;

    always_comb begin
      stg_d = stg_in[s];
      for (int j = 0; j < DIV_SPS; j++) begin
        if (s * DIV_SPS + j < DVD_W) begin
          stg_d.x = div_step(stg_d.x, stg_d.dsr);
          stg_d.y = div_step(stg_d.y, stg_d.dsr);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s] <= stg_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= (s == 0) ? vld_i : vld_q[(s == 0) ? 0 : s-1];
      end
    end

    assign stg_in[s+1] = stg_q[s];
  end

  assign vld_o  = vld_q[DIV_STG-1];
  assign side_o = stg_q[DIV_STG-1].side;
  assign qx_o   = stg_q[DIV_STG-1].x.dvd;
  assign qy_o   = stg_q[DIV_STG-1].y.dvd;

endmodule

[tb/tb_segment_intersection_point_unit.sv]
// Testbench for segment_intersection_point_unit: random and directed segment pairs,
// checked against an in-bench predictor through a small scoreboard class.
// Depends on sip_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_segment_intersection_point_unit;
  import sip_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct {
    logic meets;
    logic pvld;
    logic [PT_W-1:0] px;
    logic [PT_W-1:0] py;
  } isect_t;
  typedef struct { longint x; longint y; } pnt_t;

  localparam int LATENCY = 6 + DIV_STG;

  // Orientation of c against the directed line a->b.
  function automatic int turn_sign(pnt_t a, pnt_t b, pnt_t c);
    longint v;
    v = (b.x - a.x) * (c.y - a.y) - (b.y - a.y) * (c.x - a.x);
    return v > 0 ? 1 : (v == 0 ? 0 : -1);
  endfunction

  function automatic int lex_cmp(pnt_t a, pnt_t b);
    if (a.x != b.x) return a.x < b.x ? -1 : 1;
    if (a.y != b.y) return a.y < b.y ? -1 : 1;
    return 0;
  endfunction

  // (num << FRAC_BITS) / den truncated toward zero, low PT_W bits.
  function automatic logic [PT_W-1:0] fix_quot(logic signed [127:0] num, longint den);
    logic signed [127:0] n, d, q;
    n = num <<< FRAC_BITS;
    d = den;
    q = n / d;
    return q[PT_W-1:0];
  endfunction

  function automatic isect_t predict_isect(coord_t c[8]);
    pnt_t a, b, p, q, t;
    int ab, cd;
    longint den, e1, e2;
    isect_t r;
    logic signed [127:0] nx, ny;
    a.x = c[0]; a.y = c[1]; b.x = c[2]; b.y = c[3];
    p.x = c[4]; p.y = c[5]; q.x = c[6]; q.y = c[7];
    r = '{1'b0, 1'b0, '0, '0};
    ab = turn_sign(a, b, p) * turn_sign(a, b, q);
    cd = turn_sign(p, q, a) * turn_sign(p, q, b);
    if (ab == 0 && cd == 0) begin
      if (lex_cmp(a, b) > 0) begin t = a; a = b; b = t; end
      if (lex_cmp(p, q) > 0) begin t = p; p = q; q = t; end
      r.meets = lex_cmp(a, q) <= 0 && lex_cmp(b, p) >= 0;
    end else begin
      r.meets = ab <= 0 && cd <= 0;
    end
    if (!r.meets) return r;
    den = (a.x - b.x) * (p.y - q.y) - (a.y - b.y) * (p.x - q.x);
    if (den == 0) begin
      if (lex_cmp(b, p) == 0 && lex_cmp(a, p) <= 0) begin
        r.pvld = 1; r.px = PT_W'(b.x << FRAC_BITS); r.py = PT_W'(b.y << FRAC_BITS);
      end else if (lex_cmp(a, q) == 0 && lex_cmp(p, a) <= 0) begin
        r.pvld = 1; r.px = PT_W'(a.x << FRAC_BITS); r.py = PT_W'(a.y << FRAC_BITS);
      end
      return r;
    end
    e1 = a.x * b.y - a.y * b.x;
    e2 = p.x * q.y - p.y * q.x;
    nx = 128'(e1) * 128'(p.x - q.x) - 128'(a.x - b.x) * 128'(e2);
    ny = 128'(e1) * 128'(p.y - q.y) - 128'(a.y - b.y) * 128'(e2);
    r.pvld = 1;
    r.px = fix_quot(nx, den);
    r.py = fix_quot(ny, den);
    return r;
  endfunction

  class isect_board;
    isect_t pending[$];
    int errors;
    int checked;
    int points;

    function void note_request(coord_t c[8]);
      pending.insert(pending.size(), predict_isect(c));
    endfunction

    function void check_result(logic m, logic v, logic [PT_W-1:0] x, logic [PT_W-1:0] y);
      isect_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.pvld) points++;
      if (m !== e.meets) begin
        $error("meets: expected %0d actual %0d", e.meets, m); errors++;
      end
      if (v !== e.pvld) begin
        $error("point_valid: expected %0d actual %0d", e.pvld, v); errors++;
      end
      if (x !== e.px) begin
        $error("point_x: expected %h actual %h", e.px, x); errors++;
      end
      if (y !== e.py) begin
        $error("point_y: expected %h actual %h", e.py, y); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  coord_t s1_x0_i = '0, s1_y0_i = '0, s1_x1_i = '0, s1_y1_i = '0;
  coord_t s2_x0_i = '0, s2_y0_i = '0, s2_x1_i = '0, s2_y1_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic meets_o, point_valid_o;
  logic signed [PT_W-1:0] point_x_o, point_y_o;

  segment_intersection_point_unit uut (.*);

  isect_board board = new();
  bit quiet_phase = 0;     // no idling in the last part of the run
  int hold_sink = 0;       // cycles the receiver still holds off
  int idle_sink = 0;       // cycles left in a short receiver idle burst

  initial forever #5 clk_i = ~clk_i;

  // Drive one request and hold it until accepted.
  task automatic send_request(coord_t c[8]);
    s1_x0_i <= c[0]; s1_y0_i <= c[1]; s1_x1_i <= c[2]; s1_y1_i <= c[3];
    s2_x0_i <= c[4]; s2_y0_i <= c[5]; s2_x1_i <= c[6]; s2_y1_i <= c[7];
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(c);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      n = $urandom_range(1, 13);
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random pair, half of them shaped toward touching, collinear, point-like and crossing cases.
  task automatic rand_pair(output coord_t c[8]);
    int kind, span;
    longint dx, dy, k;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(1, 12));
    foreach (c[i]) c[i] = rnd_coord(span);
    case (kind)
      0: begin c[4] = c[2]; c[5] = c[3]; end                   // shared endpoint
      1, 2: begin                                              // same line
        dx = $signed($urandom_range(0, 8)) - 4;
        dy = $signed($urandom_range(0, 8)) - 4;
        k = $signed($urandom_range(0, 8)) - 4;
        c[2] = coord_t'(c[0] + dx * k); c[3] = coord_t'(c[1] + dy * k);
        k = $signed($urandom_range(0, 8)) - 4;
        c[4] = coord_t'(c[0] + dx * k); c[5] = coord_t'(c[1] + dy * k);
        k = $signed($urandom_range(0, 8)) - 4;
        c[6] = coord_t'(c[0] + dx * k); c[7] = coord_t'(c[1] + dy * k);
      end
      3: begin c[2] = c[0]; c[3] = c[1]; end                   // point-like segment
      4: begin                                                 // crossing through
        c[4] = c[0] + c[2] - c[6]; c[5] = c[1] + c[3] - c[7];
      end
      default: ;
    endcase
  endtask

  // Receiver: random idle bursts, plus a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_sink > 0) begin
      hold_sink <= hold_sink - 1;
      out_ready_i <= 0;
    end else if (quiet_phase) begin
      out_ready_i <= 1;
    end else if (idle_sink > 0) begin
      idle_sink <= idle_sink - 1;
      out_ready_i <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      idle_sink <= $urandom_range(1, 13) - 1;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(meets_o, point_valid_o, point_x_o, point_y_o);
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    coord_t c[8];
    coord_t mx, mn;
    int drain;
    mx = {1'b0, {(COORD_BITS-1){1'b1}}};
    mn = {1'b1, {(COORD_BITS-1){1'b0}}};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: extremes, crossing, touch both ways, overlap, disjoint, points.
    c = '{mn, mn, mx, mx, mn, mx, mx, mn}; send_request(c);
    c = '{mx, mx, mn, mn, mx, mn, mn, mx}; send_request(c);
    c = '{mn, mn, mx, mn, mn, mx, mx, mx}; send_request(c);  // parallel apart
    c = '{0, 0, 4, 4, 4, 4, 8, 8}; send_request(c);          // touch upper-lower
    c = '{4, 4, 8, 8, 0, 0, 4, 4}; send_request(c);          // touch lower-upper
    c = '{0, 0, 4, 4, 2, 2, 8, 8}; send_request(c);          // collinear overlap
    c = '{0, 0, 1, 1, 3, 3, 8, 8}; send_request(c);          // collinear apart
    c = '{2, 2, 2, 2, 0, 0, 4, 4}; send_request(c);          // point inside
    c = '{4, 4, 4, 4, 0, 0, 4, 4}; send_request(c);          // point at end
    c = '{3, 3, 3, 3, 3, 3, 3, 3}; send_request(c);          // same point
    c = '{0, 0, 3, 1, 0, 1, 3, 0}; send_request(c);          // fractional cross
    c = '{0, 0, -3, 1, 0, 1, -3, 0}; send_request(c);
    c = '{0, 0, 4, 0, 2, 0, 2, 5}; send_request(c);          // T touch
    c = '{mn, 0, mx, 0, 0, mn, 0, mx}; send_request(c);
    c = '{-1, -1, -1, -1, 0, 0, 0, 0}; send_request(c);

    // Long receiver hold-off while requests keep coming.
    hold_sink = 300;
    for (int i = 0; i < 100; i++) begin rand_pair(c); send_request(c); end
    in_valid_i <= 0;

    // Sender pause until all results are home.
    while (board.pending.size() != 0) @(negedge clk_i);

    for (int i = 0; i < 385; i++) begin
      if (i == 300) quiet_phase = 1;
      rand_pair(c);
      send_request(c);
      sender_gap();
    end
    in_valid_i <= 0;

    drain = 0;
    while (board.pending.size() != 0 && drain < 100_000) begin
      @(negedge clk_i); drain++;
    end
    repeat (LATENCY + 10) @(negedge clk_i);
    if (board.pending.size() != 0) begin
      $error("%0d results never arrived", board.pending.size());
      board.errors++;
    end
    $display("checked %0d results, %0d with a point, incl. extremes, touches, overlaps",
             board.checked, board.points);
    $display("covered a long output stall and a sender pause to empty pipeline");
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
